>>> hdl/dpfu_pkg.sv
// Shared types and constants for the DDS pixel format unpacker.
// Holds the format codes, register indexes and the result item struct.
// No dependencies.
`timescale 1ns / 1ps

package dpfu_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 32;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_RGB_FLAG     = 3'd0,
      CSR_ALPHA_PIXELS = 3'd1,
      CSR_ALPHA_ONLY   = 3'd2,
      CSR_BPP          = 3'd3,
      CSR_RED_MASK     = 3'd4,
      CSR_GREEN_MASK   = 3'd5,
      CSR_BLUE_MASK    = 3'd6,
      CSR_ALPHA_MASK   = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      FMT_BGRA8   = 4'd0,
      FMT_RGBA8   = 4'd1,
      FMT_BGR5A1  = 4'd2,
      FMT_BGR10A2 = 4'd3,
      FMT_RGB10A2 = 4'd4,
      FMT_BGRA4   = 4'd5,
      FMT_B2GR3A8 = 4'd6,
      FMT_BGR8    = 4'd7,
      FMT_RGB8    = 4'd8,
      FMT_BGR565  = 4'd9,
      FMT_B2GR3   = 4'd10,
      FMT_LUM     = 4'd11,
      FMT_LA8     = 4'd12,
      FMT_LA4     = 4'd13,
      FMT_NONE    = 4'd14
   } fmt_type;

   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [7:0] byte3;
      logic [2:0] count;
      fmt_type    fmt;
   } pix_out_type;

endpackage

>>> hdl/dpfu_fmt_decode.sv
// Pixel-format registers and layout match for the DDS pixel format unpacker.
// Holds the header registers and picks one layout in header order.
// Depends on dpfu_pkg.
`timescale 1ns / 1ps

module dpfu_fmt_decode (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [dpfu_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [dpfu_pkg::CsrDataWidth-1:0]    csr_wdata,
   output dpfu_pkg::fmt_type                    fmt
);
   import dpfu_pkg::*;

   logic        rgb_ff,   rgb_in;
   logic        apix_ff,  apix_in;
   logic        aonly_ff, aonly_in;
   logic [5:0]  bpp_ff,   bpp_in;
   logic [31:0] rmask_ff, rmask_in;
   logic [31:0] gmask_ff, gmask_in;
   logic [31:0] bmask_ff, bmask_in;
   logic [31:0] amask_ff, amask_in;

   always_comb begin
      rgb_in   = rgb_ff;
      apix_in  = apix_ff;
      aonly_in = aonly_ff;
      bpp_in   = bpp_ff;
      rmask_in = rmask_ff;
      gmask_in = gmask_ff;
      bmask_in = bmask_ff;
      amask_in = amask_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_RGB_FLAG:     rgb_in   = csr_wdata[0];
            CSR_ALPHA_PIXELS: apix_in  = csr_wdata[0];
            CSR_ALPHA_ONLY:   aonly_in = csr_wdata[0];
            CSR_BPP:          bpp_in   = csr_wdata[5:0];
            CSR_RED_MASK:     rmask_in = csr_wdata;
            CSR_GREEN_MASK:   gmask_in = csr_wdata;
            CSR_BLUE_MASK:    bmask_in = csr_wdata;
            CSR_ALPHA_MASK:   amask_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rgb_ff   <= 1'b0;
         apix_ff  <= 1'b0;
         aonly_ff <= 1'b0;
         bpp_ff   <= '0;
         rmask_ff <= '0;
         gmask_ff <= '0;
         bmask_ff <= '0;
         amask_ff <= '0;
      end else begin
         rgb_ff   <= rgb_in;
         apix_ff  <= apix_in;
         aonly_ff <= aonly_in;
         bpp_ff   <= bpp_in;
         rmask_ff <= rmask_in;
         gmask_ff <= gmask_in;
         bmask_ff <= bmask_in;
         amask_ff <= amask_in;
      end
   end

   function automatic logic rgb_is(input logic [5:0] bpp, input logic [31:0] r,
                                   input logic [31:0] g, input logic [31:0] b);
      rgb_is = (bpp_ff == bpp) && (rmask_ff == r) && (gmask_ff == g) && (bmask_ff == b);
   endfunction

   function automatic logic masks_are(input logic [5:0] bpp, input logic [31:0] r,
                                      input logic [31:0] g, input logic [31:0] b,
                                      input logic [31:0] a);
      masks_are = rgb_is(bpp, r, g, b) && (amask_ff == a);
   endfunction

   fmt_type main_fmt;

   always_comb begin
      main_fmt = FMT_NONE;
      if (rgb_ff) begin
         if (apix_ff) begin
            if (masks_are(6'd32, 32'h00ff0000, 32'h0000ff00, 32'h000000ff, 32'hff000000))
               main_fmt = FMT_BGRA8;
            else if (masks_are(6'd32, 32'h000000ff, 32'h0000ff00, 32'h00ff0000, 32'hff000000))
               main_fmt = FMT_RGBA8;
            else if (masks_are(6'd16, 32'h00007c00, 32'h000003e0, 32'h0000001f, 32'h00008000))
               main_fmt = FMT_BGR5A1;
            else if (masks_are(6'd32, 32'h3ff00000, 32'h000ffc00, 32'h000003ff, 32'hc0000000))
               main_fmt = FMT_BGR10A2;
            else if (masks_are(6'd32, 32'h000003ff, 32'h000ffc00, 32'h3ff00000, 32'hc0000000))
               main_fmt = FMT_RGB10A2;
            else if (masks_are(6'd16, 32'h00000f00, 32'h000000f0, 32'h0000000f, 32'h0000f000))
               main_fmt = FMT_BGRA4;
            else if (masks_are(6'd16, 32'h000000e0, 32'h0000001c, 32'h00000003, 32'h0000ff00))
               main_fmt = FMT_B2GR3A8;
         end else begin
            if (rgb_is(6'd24, 32'h00ff0000, 32'h0000ff00, 32'h000000ff))
               main_fmt = FMT_BGR8;
            else if (rgb_is(6'd24, 32'h000000ff, 32'h0000ff00, 32'h00ff0000))
               main_fmt = FMT_RGB8;
            else if (rgb_is(6'd16, 32'h0000f800, 32'h000007e0, 32'h0000001f))
               main_fmt = FMT_BGR565;
            else if (rgb_is(6'd8, 32'h000000e0, 32'h0000001c, 32'h00000003))
               main_fmt = FMT_B2GR3;
         end
      end else if (aonly_ff && (bpp_ff == 6'd8) && (amask_ff == 32'h000000ff)) begin
         main_fmt = FMT_LUM;
      end
   end

   // luminance fallbacks when nothing above matched
   always_comb begin
      fmt = main_fmt;
      if (main_fmt == FMT_NONE) begin
         if (apix_ff) begin
            if ((bpp_ff == 6'd16) && (rmask_ff == 32'h000000ff) && (amask_ff == 32'h0000ff00))
               fmt = FMT_LA8;
            else if ((bpp_ff == 6'd8) && (rmask_ff == 32'h0000000f)
                     && (amask_ff == 32'h000000f0))
               fmt = FMT_LA4;
         end else if ((bpp_ff == 6'd8) && (rmask_ff == 32'h000000ff)) begin
            fmt = FMT_LUM;
         end
      end
   end

endmodule

>>> hdl/dpfu_convert.sv
// Pixel conversion for the DDS pixel format unpacker.
// Slices one packed source pixel into output bytes for the selected layout.
// Depends on dpfu_pkg.
`timescale 1ns / 1ps

module dpfu_convert (
   input  dpfu_pkg::fmt_type      fmt,
   input  logic [31:0]            pixel,
   output dpfu_pkg::pix_out_type  result
);
   import dpfu_pkg::*;

   function automatic logic [7:0] nib_rep(input logic [3:0] n);
      nib_rep = {n, n};
   endfunction

   function automatic logic [7:0] two_bit_alpha(input logic [1:0] a);
      two_bit_alpha = (a == 2'b11) ? 8'hff : {a, 6'b0};
   endfunction

   logic [7:0] b0, b1, b2, b3;

   assign b0 = pixel[7:0];
   assign b1 = pixel[15:8];
   assign b2 = pixel[23:16];
   assign b3 = pixel[31:24];

   always_comb begin
      result       = '0;
      result.fmt   = fmt;
      unique case (fmt)
         FMT_BGRA8: begin
            result.byte0 = b2; result.byte1 = b1; result.byte2 = b0; result.byte3 = b3;
            result.count = 3'd4;
         end
         FMT_RGBA8: begin
            result.byte0 = b0; result.byte1 = b1; result.byte2 = b2; result.byte3 = b3;
            result.count = 3'd4;
         end
         FMT_BGR5A1: begin
            result.byte0 = {pixel[14:10], 3'b0};
            result.byte1 = {pixel[9:5], 3'b0};
            result.byte2 = {pixel[4:0], 3'b0};
            result.byte3 = pixel[15] ? 8'hff : 8'h00;
            result.count = 3'd4;
         end
         FMT_BGR10A2: begin
            result.byte0 = pixel[29:22];
            result.byte1 = pixel[19:12];
            result.byte2 = pixel[9:2];
            result.byte3 = two_bit_alpha(pixel[31:30]);
            result.count = 3'd4;
         end
         FMT_RGB10A2: begin
            result.byte0 = pixel[9:2];
            result.byte1 = pixel[19:12];
            result.byte2 = pixel[29:22];
            result.byte3 = two_bit_alpha(pixel[31:30]);
            result.count = 3'd4;
         end
         FMT_BGRA4: begin
            result.byte0 = nib_rep(b1[3:0]);
            result.byte1 = nib_rep(b0[7:4]);
            result.byte2 = nib_rep(b0[3:0]);
            result.byte3 = nib_rep(b1[7:4]);
            result.count = 3'd4;
         end
         FMT_B2GR3A8: begin
            result.byte0 = {b0[7:5], 5'b0};
            result.byte1 = {b0[4:2], 5'b0};
            result.byte2 = {b0[1:0], 6'b0};
            result.byte3 = b1;
            result.count = 3'd4;
         end
         FMT_BGR8: begin
            result.byte0 = b2; result.byte1 = b1; result.byte2 = b0;
            result.count = 3'd3;
         end
         FMT_RGB8: begin
            result.byte0 = b0; result.byte1 = b1; result.byte2 = b2;
            result.count = 3'd3;
         end
         FMT_BGR565: begin
            result.byte0 = {pixel[15:11], 3'b0};
            result.byte1 = {pixel[10:5], 2'b0};
            result.byte2 = {pixel[4:0], 3'b0};
            result.count = 3'd3;
         end
         FMT_B2GR3: begin
            result.byte0 = {b0[7:5], 5'b0};
            result.byte1 = {b0[4:2], 5'b0};
            result.byte2 = {b0[1:0], 6'b0};
            result.count = 3'd3;
         end
         FMT_LUM: begin
            result.byte0 = b0;
            result.count = 3'd1;
         end
         FMT_LA8: begin
            result.byte0 = b0; result.byte1 = b1;
            result.count = 3'd2;
         end
         FMT_LA4: begin
            result.byte0 = nib_rep(b0[3:0]);
            result.byte1 = nib_rep(b0[7:4]);
            result.count = 3'd2;
         end
         default: begin
            result.fmt   = FMT_NONE;
            result.count = 3'd0;
         end
      endcase
   end

endmodule

>>> hdl/dds_pixel_format_unpacker_top.sv
// Top level of the DDS pixel format unpacker.
// Depends on dpfu_pkg, dpfu_fmt_decode and dpfu_convert.
//
// Usage:
//   Write the header registers through csr_we/csr_index/csr_wdata while no
//   item is in flight: 0 rgb flag, 1 alpha pixels flag, 2 alpha only flag,
//   3 bits per pixel, 4..7 red, green, blue and alpha masks.
//   Each req item carries one little-endian source pixel in req_src_pixel.
//   Each rsp item carries up to four output bytes, the valid byte count and
//   the detected format; an unmatched layout gives format 14 and count 0.
//   An item moves on a rising edge with valid high and stall low.
//   Path: the accepting edge loads the input register, and the result
//   register then loads from the slice-and-select logic once it is free,
//   which raises rsp_valid.
//   Throughput is one item per cycle while rsp_stall is low; the input
//   register takes an item in the same cycle as the result register hands
//   one on. When rsp_stall is high the result register holds; one more item
//   is held in the input register, then req_stall rises.
//   Reset (synchronous) empties both stages and clears all header registers.
`timescale 1ns / 1ps

module dds_pixel_format_unpacker_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [dpfu_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [dpfu_pkg::CsrDataWidth-1:0]    csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [31:0]                          req_src_pixel,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [7:0]                           rsp_out_byte0,
   output logic [7:0]                           rsp_out_byte1,
   output logic [7:0]                           rsp_out_byte2,
   output logic [7:0]                           rsp_out_byte3,
   output logic [2:0]                           rsp_byte_count,
   output logic [3:0]                           rsp_format_id
);
   import dpfu_pkg::*;

   fmt_type     fmt;
   pix_out_type conv;

   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] s1_pixel_ff;
   logic        s2_valid_ff, s2_valid_in;
   pix_out_type s2_data_ff;
   logic        s1_load, s2_load;

   dpfu_fmt_decode u_fmt_decode (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fmt       (fmt)
   );

   dpfu_convert u_convert (
      .fmt    (fmt),
      .pixel  (s1_pixel_ff),
      .result (conv)
   );

   assign s2_load     = !s2_valid_ff || !rsp_stall;
   assign s1_load     = !s1_valid_ff || s2_load;
   assign req_stall   = !s1_load;
   assign s1_valid_in = s1_load ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && req_valid) begin
         s1_pixel_ff <= req_src_pixel;
      end
      if (s2_load && s1_valid_ff) begin
         s2_data_ff <= conv;
      end
   end

   assign rsp_valid      = s2_valid_ff;
   assign rsp_out_byte0  = s2_data_ff.byte0;
   assign rsp_out_byte1  = s2_data_ff.byte1;
   assign rsp_out_byte2  = s2_data_ff.byte2;
   assign rsp_out_byte3  = s2_data_ff.byte3;
   assign rsp_byte_count = s2_data_ff.count;
   assign rsp_format_id  = s2_data_ff.fmt;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && rsp_stall))
      else $error("req_stall raised with room in the pipeline");

   a_unsupported_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_byte_count == 3'd0) == (rsp_format_id == FMT_NONE)))
      else $error("byte count and unsupported format disagree");

   a_unused_bytes_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_byte_count != 3'd4)) |-> (rsp_out_byte3 == 8'h00))
      else $error("unused alpha byte not zero");

   a_two_cycle_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted item did not reach the result register");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for dds_pixel_format_unpacker_top: writes header register settings, streams
// pixel items with random idling and stalls, and checks every result item field by field.
// Depends on dpfu_pkg and the unpacker RTL.

module tb_top;
   import dpfu_pkg::*;

   localparam int unsigned PixelItems     = 650;
   localparam int unsigned PressureCycles = 60;
   localparam int unsigned PressurePhase  = 4;

   typedef struct packed {
      logic        rgb_on;
      logic        alpha_on;
      logic        alpha_only_on;
      logic [5:0]  bpp;
      logic [31:0] mask_r;
      logic [31:0] mask_g;
      logic [31:0] mask_b;
      logic [31:0] mask_a;
   } header_type;

   class pixel_scoreboard;
      header_type  hdr;
      pix_out_type expected_q[$];
      int          mismatches;
      logic [14:0] fmt_seen;

      function new();
         hdr        = '0;
         mismatches = 0;
         fmt_seen   = '0;
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] data);
         case (idx)
            CSR_RGB_FLAG:     hdr.rgb_on        = data[0];
            CSR_ALPHA_PIXELS: hdr.alpha_on      = data[0];
            CSR_ALPHA_ONLY:   hdr.alpha_only_on = data[0];
            CSR_BPP:          hdr.bpp           = data[5:0];
            CSR_RED_MASK:     hdr.mask_r        = data;
            CSR_GREEN_MASK:   hdr.mask_g        = data;
            CSR_BLUE_MASK:    hdr.mask_b        = data;
            CSR_ALPHA_MASK:   hdr.mask_a        = data;
         endcase
      endfunction

      function bit rgb_masks_are(int unsigned n, logic [31:0] r, logic [31:0] g,
                                 logic [31:0] b);
         return hdr.bpp == n && hdr.mask_r == r && hdr.mask_g == g && hdr.mask_b == b;
      endfunction

      function bit rgba_masks_are(int unsigned n, logic [31:0] r, logic [31:0] g,
                                  logic [31:0] b, logic [31:0] a);
         return rgb_masks_are(n, r, g, b) && hdr.mask_a == a;
      endfunction

      function fmt_type pick_layout();
         fmt_type f;
         f = FMT_NONE;
         if (hdr.rgb_on) begin
            if (hdr.alpha_on) begin
               if (rgba_masks_are(32, 32'h00ff0000, 32'h0000ff00, 32'h000000ff, 32'hff000000))
                  f = FMT_BGRA8;
               else if (rgba_masks_are(32, 32'h000000ff, 32'h0000ff00, 32'h00ff0000,
                                       32'hff000000))
                  f = FMT_RGBA8;
               else if (rgba_masks_are(16, 32'h7c00, 32'h03e0, 32'h001f, 32'h8000))
                  f = FMT_BGR5A1;
               else if (rgba_masks_are(32, 32'h3ff00000, 32'h000ffc00, 32'h000003ff,
                                       32'hc0000000))
                  f = FMT_BGR10A2;
               else if (rgba_masks_are(32, 32'h000003ff, 32'h000ffc00, 32'h3ff00000,
                                       32'hc0000000))
                  f = FMT_RGB10A2;
               else if (rgba_masks_are(16, 32'h0f00, 32'h00f0, 32'h000f, 32'hf000))
                  f = FMT_BGRA4;
               else if (rgba_masks_are(16, 32'h00e0, 32'h001c, 32'h0003, 32'hff00))
                  f = FMT_B2GR3A8;
            end else begin
               if (rgb_masks_are(24, 32'h00ff0000, 32'h0000ff00, 32'h000000ff))
                  f = FMT_BGR8;
               else if (rgb_masks_are(24, 32'h000000ff, 32'h0000ff00, 32'h00ff0000))
                  f = FMT_RGB8;
               else if (rgb_masks_are(16, 32'hf800, 32'h07e0, 32'h001f))
                  f = FMT_BGR565;
               else if (rgb_masks_are(8, 32'he0, 32'h1c, 32'h03))
                  f = FMT_B2GR3;
            end
         end else if (hdr.alpha_only_on && hdr.bpp == 6'd8 && hdr.mask_a == 32'hff) begin
            f = FMT_LUM;
         end
         if (f == FMT_NONE) begin
            if (hdr.alpha_on) begin
               if (hdr.bpp == 6'd16 && hdr.mask_r == 32'hff && hdr.mask_a == 32'hff00)
                  f = FMT_LA8;
               else if (hdr.bpp == 6'd8 && hdr.mask_r == 32'h0f && hdr.mask_a == 32'hf0)
                  f = FMT_LA4;
            end else if (hdr.bpp == 6'd8 && hdr.mask_r == 32'hff) begin
               f = FMT_LUM;
            end
         end
         return f;
      endfunction

      // top two bits scaled, with the full code pinned to 255
      function logic [7:0] alpha_from_top_bits(logic [1:0] a);
         return (a == 2'b11) ? 8'hff : {a, 6'b0};
      endfunction

      function pix_out_type unpack_pixel(logic [31:0] w);
         pix_out_type r;
         r     = '0;
         r.fmt = pick_layout();
         case (r.fmt)
            FMT_BGRA8: begin
               {r.byte0, r.byte1, r.byte2, r.byte3} = {w[23:16], w[15:8], w[7:0], w[31:24]};
               r.count = 3'd4;
            end
            FMT_RGBA8: begin
               {r.byte0, r.byte1, r.byte2, r.byte3} = {w[7:0], w[15:8], w[23:16], w[31:24]};
               r.count = 3'd4;
            end
            FMT_BGR5A1: begin
               r.byte0 = {w[14:10], 3'b0};
               r.byte1 = {w[9:5], 3'b0};
               r.byte2 = {w[4:0], 3'b0};
               r.byte3 = w[15] ? 8'hff : 8'h00;
               r.count = 3'd4;
            end
            FMT_BGR10A2: begin
               {r.byte0, r.byte1, r.byte2} = {w[29:22], w[19:12], w[9:2]};
               r.byte3 = alpha_from_top_bits(w[31:30]);
               r.count = 3'd4;
            end
            FMT_RGB10A2: begin
               {r.byte0, r.byte1, r.byte2} = {w[9:2], w[19:12], w[29:22]};
               r.byte3 = alpha_from_top_bits(w[31:30]);
               r.count = 3'd4;
            end
            FMT_BGRA4: begin
               r.byte0 = {2{w[11:8]}};
               r.byte1 = {2{w[7:4]}};
               r.byte2 = {2{w[3:0]}};
               r.byte3 = {2{w[15:12]}};
               r.count = 3'd4;
            end
            FMT_B2GR3A8: begin
               {r.byte0, r.byte1, r.byte2} = {w[7:5], 5'b0, w[4:2], 5'b0, w[1:0], 6'b0};
               r.byte3 = w[15:8];
               r.count = 3'd4;
            end
            FMT_BGR8: begin
               {r.byte0, r.byte1, r.byte2} = {w[23:16], w[15:8], w[7:0]};
               r.count = 3'd3;
            end
            FMT_RGB8: begin
               {r.byte0, r.byte1, r.byte2} = {w[7:0], w[15:8], w[23:16]};
               r.count = 3'd3;
            end
            FMT_BGR565: begin
               {r.byte0, r.byte1, r.byte2} = {w[15:11], 3'b0, w[10:5], 2'b0, w[4:0], 3'b0};
               r.count = 3'd3;
            end
            FMT_B2GR3: begin
               {r.byte0, r.byte1, r.byte2} = {w[7:5], 5'b0, w[4:2], 5'b0, w[1:0], 6'b0};
               r.count = 3'd3;
            end
            FMT_LUM: begin
               r.byte0 = w[7:0];
               r.count = 3'd1;
            end
            FMT_LA8: begin
               {r.byte0, r.byte1} = {w[7:0], w[15:8]};
               r.count = 3'd2;
            end
            FMT_LA4: begin
               r.byte0 = {2{w[3:0]}};
               r.byte1 = {2{w[7:4]}};
               r.count = 3'd2;
            end
            default: r.count = 3'd0;
         endcase
         fmt_seen[r.fmt] = 1'b1;
         return r;
      endfunction

      function void note_pixel(logic [31:0] w);
         expected_q = {expected_q, unpack_pixel(w)};
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= 40)
            $display("mismatch %0d at %0t: %s", mismatches, $time, msg);
      endtask

      task check_result(pix_out_type got);
         pix_out_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result item, format %0d", got.fmt));
            return;
         end
         want = expected_q.pop_front();
         if (got.byte0 !== want.byte0)
            report_mismatch($sformatf("byte0 %02h, want %02h (fmt %0d)",
                                      got.byte0, want.byte0, want.fmt));
         if (got.byte1 !== want.byte1)
            report_mismatch($sformatf("byte1 %02h, want %02h (fmt %0d)",
                                      got.byte1, want.byte1, want.fmt));
         if (got.byte2 !== want.byte2)
            report_mismatch($sformatf("byte2 %02h, want %02h (fmt %0d)",
                                      got.byte2, want.byte2, want.fmt));
         if (got.byte3 !== want.byte3)
            report_mismatch($sformatf("byte3 %02h, want %02h (fmt %0d)",
                                      got.byte3, want.byte3, want.fmt));
         if (got.count !== want.count)
            report_mismatch($sformatf("byte count %0d, want %0d (fmt %0d)",
                                      got.count, want.count, want.fmt));
         if (got.fmt !== want.fmt)
            report_mismatch($sformatf("format %0d, want %0d", got.fmt, want.fmt));
      endtask

      task check_drained();
         if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d result items never arrived", expected_q.size()));
      endtask
   endclass

   logic                     clock         = 1'b0;
   logic                     reset         = 1'b1;
   logic                     csr_we        = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index     = '0;
   logic [CsrDataWidth-1:0]  csr_wdata     = '0;
   logic                     req_valid     = 1'b0;
   logic                     req_stall;
   logic [31:0]              req_src_pixel = '0;
   logic                     rsp_valid;
   logic                     rsp_stall     = 1'b0;
   logic [7:0]               rsp_out_byte0;
   logic [7:0]               rsp_out_byte1;
   logic [7:0]               rsp_out_byte2;
   logic [7:0]               rsp_out_byte3;
   logic [2:0]               rsp_byte_count;
   logic [3:0]               rsp_format_id;

   pixel_scoreboard sb;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;
   int items_sent     = 0;
   int headers_written = 0;

   dds_pixel_format_unpacker_top u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_src_pixel  (req_src_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte0  (rsp_out_byte0),
      .rsp_out_byte1  (rsp_out_byte1),
      .rsp_out_byte2  (rsp_out_byte2),
      .rsp_out_byte3  (rsp_out_byte3),
      .rsp_byte_count (rsp_byte_count),
      .rsp_format_id  (rsp_format_id)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // receiver: long hold-off when requested, otherwise random stalls
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // sampled mid-cycle so the accepting edge is decided by settled values
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(pix_out_type'({rsp_out_byte0, rsp_out_byte1, rsp_out_byte2,
                                        rsp_out_byte3, rsp_byte_count, rsp_format_id}));
   end

   function automatic header_type header_for(fmt_type f);
      header_type h;
      h.rgb_on        = 1'($urandom_range(1));
      h.alpha_on      = 1'($urandom_range(1));
      h.alpha_only_on = 1'($urandom_range(1));
      h.bpp           = 6'($urandom_range(63));
      h.mask_r        = $urandom();
      h.mask_g        = $urandom();
      h.mask_b        = $urandom();
      h.mask_a        = $urandom();
      case (f)
         FMT_BGRA8: begin
            {h.rgb_on, h.alpha_on, h.bpp} = {2'b11, 6'd32};
            {h.mask_r, h.mask_g, h.mask_b, h.mask_a} =
               {32'h00ff0000, 32'h0000ff00, 32'h000000ff, 32'hff000000};
         end
         FMT_RGBA8: begin
            {h.rgb_on, h.alpha_on, h.bpp} = {2'b11, 6'd32};
            {h.mask_r, h.mask_g, h.mask_b, h.mask_a} =
               {32'h000000ff, 32'h0000ff00, 32'h00ff0000, 32'hff000000};
         end
         FMT_BGR5A1: begin
            {h.rgb_on, h.alpha_on, h.bpp} = {2'b11, 6'd16};
            {h.mask_r, h.mask_g, h.mask_b, h.mask_a} =
               {32'h7c00, 32'h03e0, 32'h001f, 32'h8000};
         end
         FMT_BGR10A2: begin
            {h.rgb_on, h.alpha_on, h.bpp} = {2'b11, 6'd32};
            {h.mask_r, h.mask_g, h.mask_b, h.mask_a} =
               {32'h3ff00000, 32'h000ffc00, 32'h000003ff, 32'hc0000000};
         end
         FMT_RGB10A2: begin
            {h.rgb_on, h.alpha_on, h.bpp} = {2'b11, 6'd32};
            {h.mask_r, h.mask_g, h.mask_b, h.mask_a} =
               {32'h000003ff, 32'h000ffc00, 32'h3ff00000, 32'hc0000000};
         end
         FMT_BGRA4: begin
            {h.rgb_on, h.alpha_on, h.bpp} = {2'b11, 6'd16};
            {h.mask_r, h.mask_g, h.mask_b, h.mask_a} =
               {32'h0f00, 32'h00f0, 32'h000f, 32'hf000};
         end
         FMT_B2GR3A8: begin
            {h.rgb_on, h.alpha_on, h.bpp} = {2'b11, 6'd16};
            {h.mask_r, h.mask_g, h.mask_b, h.mask_a} =
               {32'h00e0, 32'h001c, 32'h0003, 32'hff00};
         end
         FMT_BGR8: begin
            {h.rgb_on, h.alpha_on, h.bpp} = {2'b10, 6'd24};
            {h.mask_r, h.mask_g, h.mask_b} = {32'h00ff0000, 32'h0000ff00, 32'h000000ff};
         end
         FMT_RGB8: begin
            {h.rgb_on, h.alpha_on, h.bpp} = {2'b10, 6'd24};
            {h.mask_r, h.mask_g, h.mask_b} = {32'h000000ff, 32'h0000ff00, 32'h00ff0000};
         end
         FMT_BGR565: begin
            {h.rgb_on, h.alpha_on, h.bpp} = {2'b10, 6'd16};
            {h.mask_r, h.mask_g, h.mask_b} = {32'hf800, 32'h07e0, 32'h001f};
         end
         FMT_B2GR3: begin
            {h.rgb_on, h.alpha_on, h.bpp} = {2'b10, 6'd8};
            {h.mask_r, h.mask_g, h.mask_b} = {32'he0, 32'h1c, 32'h03};
         end
         FMT_LUM: begin
            h.bpp = 6'd8;
            if ($urandom_range(1)) begin
               {h.rgb_on, h.alpha_only_on, h.mask_a} = {2'b01, 32'hff};
            end else begin
               {h.alpha_on, h.mask_r} = {1'b0, 32'hff};
            end
         end
         FMT_LA8: begin
            {h.alpha_on, h.bpp, h.mask_r, h.mask_a} = {1'b1, 6'd16, 32'hff, 32'hff00};
         end
         FMT_LA4: begin
            {h.alpha_on, h.bpp, h.mask_r, h.mask_a} = {1'b1, 6'd8, 32'h0f, 32'hf0};
         end
         default: ;
      endcase
      return h;
   endfunction

   // all eight registers, flag and bpp words carrying random upper bits
   task automatic write_header(input header_type h);
      logic [31:0] data;
      for (int i = 0; i < 8; i++) begin
         data = $urandom();
         case (csr_index_type'(i))
            CSR_RGB_FLAG:     data[0]   = h.rgb_on;
            CSR_ALPHA_PIXELS: data[0]   = h.alpha_on;
            CSR_ALPHA_ONLY:   data[0]   = h.alpha_only_on;
            CSR_BPP:          data[5:0] = h.bpp;
            CSR_RED_MASK:     data      = h.mask_r;
            CSR_GREEN_MASK:   data      = h.mask_g;
            CSR_BLUE_MASK:    data      = h.mask_b;
            CSR_ALPHA_MASK:   data      = h.mask_a;
         endcase
         csr_we    <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= data;
         sb.write_reg(csr_index_type'(i), data);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      headers_written++;
   endtask

   task automatic send_pixel(input logic [31:0] pix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_src_pixel <= pix;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      sb.note_pixel(pix);
      items_sent++;
      @(posedge clock);
   endtask

   task automatic run_batch(input logic [31:0] pixels[$]);
      foreach (pixels[i]) send_pixel(pixels[i]);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   initial begin : stimulus
      header_type       h;
      logic [$bits(header_type)-1:0] hbits;
      logic [31:0]      pixels[$];
      int               phase;
      int               count;
      int               kind;

      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // header registers still at reset: nothing matches
      pixels = '{32'h0000_0000, 32'hffff_ffff};
      run_batch(pixels);
      // two-bit alpha codes and ten-bit channel extremes
      write_header(header_for(FMT_BGR10A2));
      pixels = '{32'h0000_0000, 32'hffff_ffff, 32'h4000_0000, 32'h8000_0000,
                 32'hc000_0000, 32'h3ff0_03ff};
      run_batch(pixels);
      write_header(header_for(FMT_BGR5A1));
      pixels = '{32'h0000_8000, 32'hffff_7fff};
      run_batch(pixels);
      write_header(header_for(FMT_BGRA4));
      pixels = '{32'h1234_a5f0};
      run_batch(pixels);
      write_header(header_for(FMT_LA4));
      pixels = '{32'hffff_ff5a};
      run_batch(pixels);
      write_header('1);
      pixels = '{32'hffff_ffff};
      run_batch(pixels);
      write_header(header_for(FMT_B2GR3));
      pixels = '{32'hffff_ffff, 32'h0000_0003};
      run_batch(pixels);
      write_header(header_for(FMT_BGR565));
      pixels = '{32'h0000_ffff, 32'hffff_f800};
      run_batch(pixels);

      phase = 0;
      while (items_sent < PixelItems) begin
         case (phase % 4)
            0:       {send_idle_pct, recv_stall_pct} = {32'd0, 32'd0};
            1:       {send_idle_pct, recv_stall_pct} = {32'd69, 32'd0};
            2:       {send_idle_pct, recv_stall_pct} = {32'd0, 32'd69};
            default: {send_idle_pct, recv_stall_pct} = {32'd7, 32'd7};
         endcase
         if (phase < 15) begin
            h = header_for(fmt_type'(phase));
         end else begin
            kind = $urandom_range(9);
            if (kind <= 4) begin
               h = header_for(fmt_type'($urandom_range(13)));
            end else if (kind <= 6) begin
               // near miss: one register bit off a valid layout
               hbits = header_for(fmt_type'($urandom_range(13)));
               hbits[$urandom_range($bits(header_type)-1)] ^= 1'b1;
               h = hbits;
            end else if (kind == 7) begin
               h = header_for(FMT_NONE);
            end else if (kind == 8) begin
               h = '1;
            end else begin
               h = '0;
            end
         end
         write_header(h);
         count = (phase == PressurePhase) ? 45 : $urandom_range(15, 35);
         pixels = {};
         repeat (count) begin
            case ($urandom_range(9))
               0:       pixels = {pixels, 32'h0000_0000};
               1:       pixels = {pixels, 32'hffff_ffff};
               default: pixels = {pixels, 32'($urandom())};
            endcase
         end
         if (phase == PressurePhase)
            hold_left = PressureCycles;
         run_batch(pixels);
         phase++;
      end

      repeat (4) @(posedge clock);
      sb.check_drained();
      $display("Run covered %0d pixel items under %0d header settings; %0d of 15 format codes",
               items_sent, headers_written, $countones(sb.fmt_seen));
      $display("were produced, with free-running, idle, stalled and held-off stretches.");
      if (sb.mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

>>> sim.f
hdl/dpfu_pkg.sv
hdl/dpfu_fmt_decode.sv
hdl/dpfu_convert.sv
hdl/dds_pixel_format_unpacker_top.sv
tb/tb_top.sv
